>>> rtl/core/gba_pkg.sv
`default_nettype none

package gba_pkg;

	// Geometry limits of the bitmap store.
	localparam int MAX_GROUPS = 16;
	localparam int MAX_BLOCKS_PER_GROUP = 8192;
	localparam int WORD_BITS = 32;
	localparam int TOTAL_BITS = MAX_GROUPS * MAX_BLOCKS_PER_GROUP;
	localparam int NUM_WORDS = TOTAL_BITS / WORD_BITS;
	localparam int WORD_AW = $clog2(NUM_WORDS);
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int GROUP_W = $clog2(MAX_GROUPS);

	// Field widths.
	localparam int BLK_W = 17;
	localparam int TOTAL_W = 18;
	localparam int BPG_W = 14;
	localparam int GCNT_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 14;
	localparam int GROUP_FREE_MAX = 16383;
	localparam int TOTAL_FREE_MAX = 262143;

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_ALREADY_FREE = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BPG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GCOUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FDB = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_GROUP,
		S_A_READ,
		S_A_CHECK,
		S_F_CHECK,
		S_F_WAIT,
		S_DONE
	} state_t;

	// Bitmap memory request.
	typedef struct packed {
		logic we;
		logic re;
		logic [WORD_AW-1:0] addr;
		logic [WORD_BITS-1:0] wdata;
	} ram_req_t;

	// Group divider request and response.
	typedef struct packed {
		logic start;
		logic [BLK_W-1:0] dividend;
		logic [BPG_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [GROUP_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/grouped_bitmap_block_allocator.sv
`default_nettype none

// Channel | Signals                                  | Transaction
// command | start, busy, command, block_number       | start high while busy low
// result  | done, allocated_block, status, total_free| done high for one cycle
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid and cfg_ready high
//
// After reset a clearing pass writes 4096 bitmap words, one per cycle, with busy high.
// A free is checked and then waits for the group divider (one subtract per cycle) before
// the result strobe; an invalid block goes straight to the result strobe.
// An allocate reads and then checks each bitmap word scanned, checks each group it reaches
// (including the end check when nothing is found) and ends with the result strobe; the single
// memory port with its registered read sets that order.
// The result cannot be stalled; busy stays high until the result cycle ends.
// Configuration is accepted only while busy is low.
module grouped_bitmap_block_allocator
	import gba_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic command,
	input wire logic [BLK_W-1:0] block_number,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic done,
	output logic [BLK_W-1:0] allocated_block,
	output logic [1:0] status,
	output logic [TOTAL_W-1:0] total_free
);

	state_t state_q, state_d;

	logic [BPG_W-1:0] bpg_q;
	logic [GCNT_W-1:0] gcount_q;
	logic fdb_q;

	logic [WORD_AW-1:0] clr_q;
	logic [BLK_W-1:0] blk_q;
	logic [GCNT_W-1:0] g_q;
	logic [TOTAL_W-1:0] base_q;
	logic [BLK_W-1:0] lo_q;
	logic [WORD_AW-1:0] waddr_q;
	logic [WORD_AW-1:0] lastw_q;
	logic [BPG_W-1:0] group_free_q [MAX_GROUPS];
	logic [TOTAL_W-1:0] free_total_q;
	logic [BLK_W-1:0] res_block_q;
	logic [1:0] res_status_q;

	ram_req_t ram_req;
	logic [WORD_BITS-1:0] ram_rdata;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic accept;
	logic cfg_write;
	logic [BPG_W-1:0] cfg_bpg;
	logic [GCNT_W-1:0] cfg_gcount;
	logic grp_end;
	logic grp_empty;
	logic [TOTAL_W-1:0] lo_sum;
	logic [TOTAL_W-1:0] hi_sum;
	logic [TOTAL_W-1:0] hi_last;
	logic [BIT_W-1:0] lo_off;
	logic [BIT_W-1:0] hi_off;
	logic [WORD_BITS-1:0] free_bits;
	logic found;
	logic [BIT_W-1:0] pos;
	logic [GCNT_W+BPG_W-1:0] limit;
	logic free_bad;
	logic bit_used;

	gba_bitmap_ram u_ram (
		.clk(clk),
		.req(ram_req),
		.rdata(ram_rdata)
	);

	gba_group_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign accept = start && !busy;
	assign cfg_ready = !busy;
	assign cfg_write = cfg_valid && cfg_ready;

	// Saturate written geometry to the supported range.
	always_comb begin
		cfg_bpg = cfg_data;
		if (cfg_bpg < BPG_W'(8)) begin
			cfg_bpg = BPG_W'(8);
		end else if (cfg_bpg > BPG_W'(MAX_BLOCKS_PER_GROUP)) begin
			cfg_bpg = BPG_W'(MAX_BLOCKS_PER_GROUP);
		end
		cfg_gcount = cfg_data[GCNT_W-1:0];
		if (cfg_gcount == '0) begin
			cfg_gcount = GCNT_W'(1);
		end else if (cfg_gcount > GCNT_W'(MAX_GROUPS)) begin
			cfg_gcount = GCNT_W'(MAX_GROUPS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpg_q <= BPG_W'(MAX_BLOCKS_PER_GROUP);
			gcount_q <= GCNT_W'(MAX_GROUPS);
			fdb_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BPG: bpg_q <= cfg_bpg;
				REG_GCOUNT: gcount_q <= cfg_gcount;
				REG_FDB: fdb_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Search window of the current group, first clear bit in the current word and the free checks.
	always_comb begin
		grp_end = g_q >= gcount_q;
		grp_empty = group_free_q[g_q[GROUP_W-1:0]] == '0;
		lo_sum = base_q + TOTAL_W'((g_q == '0) ? fdb_q : 1'b0);
		hi_sum = base_q + TOTAL_W'(bpg_q);
		hi_last = hi_sum - 1'b1;
		lo_off = (waddr_q == lo_q[BLK_W-1:BIT_W]) ? lo_q[BIT_W-1:0] : '0;
		hi_off = (waddr_q == lastw_q) ? BIT_W'(blk_q[BIT_W-1:0]) : '1;
		for (int p = 0; p < WORD_BITS; p++) begin
			free_bits[p] = !ram_rdata[p] && (BIT_W'(p) >= lo_off) && (BIT_W'(p) <= hi_off);
		end
		found = |free_bits;
		pos = '0;
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (free_bits[p]) begin
				pos = BIT_W'(p);
			end
		end
		limit = GCNT_W'(gcount_q) * BPG_W'(bpg_q);
		free_bad = (blk_q == '0) || ((GCNT_W+BPG_W)'(blk_q) >= limit);
		bit_used = ram_rdata[blk_q[BIT_W-1:0]];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					state_d = (command == CMD_FREE) ? S_F_CHECK : S_A_GROUP;
				end
			end
			S_A_GROUP: begin
				if (grp_end) begin
					state_d = S_DONE;
				end else if (!grp_empty) begin
					state_d = S_A_READ;
				end
			end
			S_A_READ: state_d = S_A_CHECK;
			S_A_CHECK: begin
				if (found) begin
					state_d = S_DONE;
				end else if (waddr_q == lastw_q) begin
					state_d = S_A_GROUP;
				end else begin
					state_d = S_A_READ;
				end
			end
			S_F_CHECK: state_d = free_bad ? S_DONE : S_F_WAIT;
			S_F_WAIT: if (div_rsp.done) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs: memory port, divider start and the result strobe.
	always_comb begin
		ram_req = '0;
		div_req.start = 1'b0;
		div_req.dividend = blk_q;
		div_req.divisor = bpg_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_req.we = 1'b1;
				ram_req.addr = clr_q;
				ram_req.wdata = '1;
			end
			S_A_READ: begin
				ram_req.re = 1'b1;
				ram_req.addr = waddr_q;
			end
			S_A_CHECK: begin
				ram_req.we = found;
				ram_req.addr = waddr_q;
				ram_req.wdata = ram_rdata | (WORD_BITS'(1) << pos);
			end
			S_F_CHECK: begin
				ram_req.re = !free_bad;
				ram_req.addr = blk_q[BLK_W-1:BIT_W];
				div_req.start = !free_bad;
			end
			S_F_WAIT: begin
				ram_req.we = div_rsp.done && bit_used;
				ram_req.addr = blk_q[BLK_W-1:BIT_W];
				ram_req.wdata = ram_rdata & ~(WORD_BITS'(1) << blk_q[BIT_W-1:0]);
			end
			default: ;
		endcase
		busy = state_q != S_IDLE;
		done = state_q == S_DONE;
	end

	assign allocated_block = res_block_q;
	assign status = res_status_q;
	assign total_free = free_total_q;

	// Control state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			free_total_q <= '0;
			for (int i = 0; i < MAX_GROUPS; i++) begin
				group_free_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			// Allocation takes a block from the group being scanned.
			if (state_q == S_A_CHECK && found) begin
				if (group_free_q[g_q[GROUP_W-1:0]] != '0) begin
					group_free_q[g_q[GROUP_W-1:0]] <= group_free_q[g_q[GROUP_W-1:0]] - 1'b1;
				end
				if (free_total_q != '0) begin
					free_total_q <= free_total_q - 1'b1;
				end
			end
			// A successful free returns the block to its group.
			if (state_q == S_F_WAIT && div_rsp.done && bit_used) begin
				if (group_free_q[div_rsp.quotient] != BPG_W'(GROUP_FREE_MAX)) begin
					group_free_q[div_rsp.quotient] <= group_free_q[div_rsp.quotient] + 1'b1;
				end
				if (free_total_q != TOTAL_W'(TOTAL_FREE_MAX)) begin
					free_total_q <= free_total_q + 1'b1;
				end
			end
		end
	end

	// Search registers and result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				blk_q <= block_number;
				g_q <= '0;
				base_q <= '0;
			end
			S_A_GROUP: begin
				if (grp_end) begin
					res_block_q <= '0;
					res_status_q <= ST_NO_FREE;
				end else if (grp_empty) begin
					g_q <= g_q + 1'b1;
					base_q <= hi_sum;
				end else begin
					lo_q <= lo_sum[BLK_W-1:0];
					waddr_q <= lo_sum[BLK_W-1:BIT_W];
					lastw_q <= hi_last[BLK_W-1:BIT_W];
					blk_q <= BLK_W'(hi_last[BIT_W-1:0]);
				end
			end
			S_A_CHECK: begin
				if (found) begin
					res_block_q <= {waddr_q, pos};
					res_status_q <= ST_OK;
				end else if (waddr_q == lastw_q) begin
					g_q <= g_q + 1'b1;
					base_q <= hi_sum;
				end else begin
					waddr_q <= waddr_q + 1'b1;
				end
			end
			S_F_CHECK: begin
				res_block_q <= '0;
				res_status_q <= ST_INVALID;
			end
			S_F_WAIT: begin
				res_status_q <= bit_used ? ST_OK : ST_ALREADY_FREE;
			end
			default: ;
		endcase
	end

	// The result strobe lasts one cycle and is followed by idle.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	// An accepted command keeps the block busy.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("command accepted without going busy");

	// The total free count moves only with a bitmap write.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(free_total_q) |-> $past(ram_req.we))
		else $error("free count changed without a bitmap write");

	// Memory never reads and writes in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(ram_req.we && ram_req.re))
		else $error("bitmap read and write collide");

endmodule

`default_nettype wire

>>> rtl/core/gba_bitmap_ram.sv
`default_nettype none

module gba_bitmap_ram
	import gba_pkg::*;
(
	input wire logic clk,
	input wire ram_req_t req,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];

	// Single port: one write and one registered read per cycle, both at one address.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/gba_group_div.sv
`default_nettype none

module gba_group_div
	import gba_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output div_rsp_t rsp
);

	logic running_q;
	logic [BLK_W-1:0] rem_q;
	logic [BPG_W-1:0] div_q;
	logic [GROUP_W:0] quo_q;
	logic fits;

	// The remainder drops by one divisor per cycle until it is below it.
	assign fits = rem_q >= BLK_W'(div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
		end else if (req.start) begin
			running_q <= 1'b1;
		end else if (running_q && !fits) begin
			running_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			div_q <= req.divisor;
			quo_q <= '0;
		end else if (running_q && fits) begin
			rem_q <= rem_q - BLK_W'(div_q);
			quo_q <= quo_q + 1'b1;
		end
	end

	assign rsp.done = running_q && !fits;
	assign rsp.quotient = quo_q[GROUP_W-1:0];

endmodule

`default_nettype wire
